// ----- hdl/euler_to_basis_vectors_defines.svh -----
// Assertion macros for the euler_to_basis_vectors checker.
// Depends on nothing; included by the checker file only.
`ifndef EULER_TO_BASIS_VECTORS_DEFINES_SVH
`define EULER_TO_BASIS_VECTORS_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle.
`define E2B_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define E2B_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hdl/e2b_pkg.sv -----
// Package for euler_to_basis_vectors: widths, sine coefficients, helpers.
// Depends on nothing.
`default_nettype none
package e2b_pkg;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int OUT_W          = 16;
	localparam int Q30_W          = 31;
	localparam int POLY_TERMS     = 6;
	localparam logic [Q30_W-1:0] Q30_ONE = 31'd1073741824;

	// Odd sine polynomial coefficients in Q30, low order first
	function automatic logic [Q30_W-1:0] sin_coef(input logic [2:0] k);
		logic [Q30_W-1:0] c;
		case (k)
			3'd0: c = 31'd1686629713;
			3'd1: c = 31'd693598669;
			3'd2: c = 31'd85569306;
			3'd3: c = 31'd5026994;
			3'd4: c = 31'd172273;
			3'd5: c = 31'd3864;
			default: c = '0;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/e2b_cell.sv -----
// One Horner step cell for the quarter-sine chain of euler_to_basis_vectors.
// Depends on e2b_pkg.
`default_nettype none
module e2b_cell #(
	parameter int CW = 8
) (
	input  wire logic                          clk,
	input  wire logic [e2b_pkg::Q30_W-1:0]     coef,
	input  wire logic [CW-1:0]                 ctl_in,
	input  wire logic [6*e2b_pkg::Q30_W-1:0]   t2_in,
	input  wire logic [6*e2b_pkg::Q30_W-1:0]   acc_in,
	input  wire logic [6*e2b_pkg::Q30_W-1:0]   t_in,
	output logic      [CW-1:0]                 ctl_out,
	output logic      [6*e2b_pkg::Q30_W-1:0]   t2_out,
	output logic      [6*e2b_pkg::Q30_W-1:0]   acc_out,
	output logic      [6*e2b_pkg::Q30_W-1:0]   t_out
);
	localparam int W = e2b_pkg::Q30_W;
	logic [6*W-1:0] acc_d;

	// acc = sat(coef - round(t2*acc)) for six lanes (sin and cos of three angles)
	always_comb begin
		logic [2*W-1:0] p;
		logic [W-1:0] m;
		for (int i = 0; i < 6; i++) begin
			p = t2_in[i*W +: W] * acc_in[i*W +: W] + (62'd1 << 29);
			m = p[W+29:30] > {{(W+1-W){1'b0}}, {W{1'b1}}} ? {W{1'b1}} : p[30 +: W];
			if (p[2*W-1:30] > {{(W+1){1'b0}}, coef}) acc_d[i*W +: W] = '0;
			else acc_d[i*W +: W] = coef - p[30 +: W];
			if (m == '0) acc_d[i*W +: W] = coef;
		end
	end

	// advance to the neighbor cell
	always_ff @(posedge clk) begin
		ctl_out <= ctl_in;
		t2_out  <= t2_in;
		acc_out <= acc_d;
		t_out   <= t_in;
	end
endmodule
`default_nettype wire

// ----- hdl/euler_to_basis_vectors.sv -----
// Top level of euler_to_basis_vectors: chain of Horner cells, then product stages.
// Depends on e2b_pkg and e2b_cell.
// Usage: one orientation can be started every clock (busy stays low); each
// result appears with done high for one cycle once its start transfer has
// passed one stage for the offsets and t squared, five Horner cells, one
// final multiply and rounding stage, one sign stage, two product stages and
// the output register. The receiver cannot stall the block.
`default_nettype none
module euler_to_basis_vectors #(
	parameter int ANGLE_BITS = e2b_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = e2b_pkg::FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [15:0]               pitch_angle,
	input  wire logic [15:0]               yaw_angle,
	input  wire logic [15:0]               roll_angle,
	output logic                           done,
	output logic signed [15:0]             forward_x,
	output logic signed [15:0]             forward_y,
	output logic signed [15:0]             forward_z,
	output logic signed [15:0]             right_x,
	output logic signed [15:0]             right_y,
	output logic signed [15:0]             right_z,
	output logic signed [15:0]             up_x,
	output logic signed [15:0]             up_y,
	output logic signed [15:0]             up_z
);
	localparam int W  = e2b_pkg::Q30_W;
	localparam int NC = e2b_pkg::POLY_TERMS - 1;
	localparam int CW = 6;
	localparam int FW = FRAC_BITS + 3;
	localparam int PW = 2*FW;

	assign busy = 1'b0;

	// split each angle into quadrant and Q30 offset
	logic [ANGLE_BITS-1:0] ang [3];
	logic [CW-1:0] quad_s1;
	logic [6*W-1:0] t_s1, t2_s1, acc0_s1;
	logic v_s1;
	assign ang[0] = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS-16 : 1){1'b0}}, pitch_angle});
	assign ang[1] = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS-16 : 1){1'b0}}, yaw_angle});
	assign ang[2] = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS-16 : 1){1'b0}}, roll_angle});

	// lane 2a is sine, lane 2a+1 is cosine (argument 1 - t)
	always_ff @(posedge clk) begin
		logic [W-1:0] t;
		logic [W-1:0] u;
		logic [2*W-1:0] tt, uu;
		for (int a = 0; a < 3; a++) begin
			t = W'({ang[a][ANGLE_BITS-3:0], 1'b0}) << (31 - ANGLE_BITS);
			u = e2b_pkg::Q30_ONE - t;
			tt = t * t + (62'd1 << 29);
			uu = u * u + (62'd1 << 29);
			quad_s1[2*a +: 2]   <= ang[a][ANGLE_BITS-1 -: 2];
			t_s1[2*a*W +: W]    <= t;
			t_s1[(2*a+1)*W +: W] <= u;
			t2_s1[2*a*W +: W]   <= tt[30 +: W];
			t2_s1[(2*a+1)*W +: W] <= uu[30 +: W];
			acc0_s1[2*a*W +: W] <= e2b_pkg::sin_coef(3'd5);
			acc0_s1[(2*a+1)*W +: W] <= e2b_pkg::sin_coef(3'd5);
		end
	end

	// chain of Horner cells, one coefficient each
	logic [CW-1:0]  ctl_c [NC+1];
	logic [6*W-1:0] t2_c  [NC+1];
	logic [6*W-1:0] acc_c [NC+1];
	logic [6*W-1:0] t_c   [NC+1];
	assign ctl_c[0] = quad_s1;
	assign t2_c[0]  = t2_s1;
	assign acc_c[0] = acc0_s1;
	assign t_c[0]   = t_s1;
	for (genvar g = 0; g < NC; g++) begin : g_cell
		e2b_cell #(.CW(CW)) u_cell (
			.clk    (clk),
			.coef   (e2b_pkg::sin_coef(3'(NC-1-g))),
			.ctl_in (ctl_c[g]),
			.t2_in  (t2_c[g]),
			.acc_in (acc_c[g]),
			.t_in   (t_c[g]),
			.ctl_out(ctl_c[g+1]),
			.t2_out (t2_c[g+1]),
			.acc_out(acc_c[g+1]),
			.t_out  (t_c[g+1])
		);
	end

	// final multiply by t, clamp, round to FRAC_BITS
	logic [CW-1:0] quad_s2;
	logic [FW-1:0] mag_s2 [6];
	always_ff @(posedge clk) begin
		logic [2*W-1:0] p;
		logic [W-1:0] m;
		logic [W:0] r;
		for (int i = 0; i < 6; i++) begin
			p = t_c[NC][i*W +: W] * acc_c[NC][i*W +: W] + (62'd1 << 29);
			m = (p[2*W-1:30] > {1'b0, e2b_pkg::Q30_ONE}) ? e2b_pkg::Q30_ONE : p[30 +: W];
			if (FRAC_BITS >= 30) r = {1'b0, m};
			else r = ({1'b0, m} + ((W+1)'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
			mag_s2[i] <= FW'(r);
		end
		quad_s2 <= ctl_c[NC];
	end

	// apply quadrant symmetry
	logic signed [FW-1:0] sv_s3 [3], cv_s3 [3];
	always_ff @(posedge clk) begin
		logic signed [FW-1:0] s0, c0;
		for (int a = 0; a < 3; a++) begin
			s0 = $signed(mag_s2[2*a]);
			c0 = $signed(mag_s2[2*a+1]);
			case (quad_s2[2*a +: 2])
				2'd0: begin sv_s3[a] <= s0;  cv_s3[a] <= c0;  end
				2'd1: begin sv_s3[a] <= c0;  cv_s3[a] <= -s0; end
				2'd2: begin sv_s3[a] <= -s0; cv_s3[a] <= -c0; end
				default: begin sv_s3[a] <= -c0; cv_s3[a] <= s0; end
			endcase
		end
	end

	function automatic logic signed [FW-1:0] mulr(input logic signed [FW-1:0] a,
			input logic signed [FW-1:0] b);
		logic [FW-1:0] ma, mb;
		logic [PW-1:0] m;
		ma = a[FW-1] ? FW'(-a) : a;
		mb = b[FW-1] ? FW'(-b) : b;
		m = (PW'(ma) * PW'(mb) + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return (a[FW-1] ^ b[FW-1]) ? -FW'(m) : FW'(m);
	endfunction

	// first products
	logic signed [FW-1:0] sp_s4, cp_s4, sy_s4, cy_s4, sr_s4, cr_s4, srsp_s4, crsp_s4;
	always_ff @(posedge clk) begin
		sp_s4 <= sv_s3[0]; cp_s4 <= cv_s3[0];
		sy_s4 <= sv_s3[1]; cy_s4 <= cv_s3[1];
		sr_s4 <= sv_s3[2]; cr_s4 <= cv_s3[2];
		srsp_s4 <= mulr(sv_s3[2], sv_s3[0]);
		crsp_s4 <= mulr(cv_s3[2], sv_s3[0]);
	end

	// second products
	logic signed [FW-1:0] p_s5 [12];
	logic signed [FW-1:0] spn_s5;
	always_ff @(posedge clk) begin
		p_s5[0]  <= mulr(cp_s4, cy_s4);
		p_s5[1]  <= mulr(cp_s4, sy_s4);
		p_s5[2]  <= mulr(srsp_s4, cy_s4);
		p_s5[3]  <= mulr(cr_s4, sy_s4);
		p_s5[4]  <= mulr(srsp_s4, sy_s4);
		p_s5[5]  <= mulr(cr_s4, cy_s4);
		p_s5[6]  <= mulr(sr_s4, cp_s4);
		p_s5[7]  <= mulr(crsp_s4, cy_s4);
		p_s5[8]  <= mulr(sr_s4, sy_s4);
		p_s5[9]  <= mulr(crsp_s4, sy_s4);
		p_s5[10] <= mulr(sr_s4, cy_s4);
		p_s5[11] <= mulr(cr_s4, cp_s4);
		spn_s5   <= -sp_s4;
	end

	function automatic logic [15:0] emit(input logic signed [FW:0] v);
		logic signed [FW:0] one;
		one = (FW+1)'(1) <<< FRAC_BITS;
		if (v > one) v = one;
		if (v < -one) v = -one;
		return 16'(v);
	endfunction

	// sums, saturation, output register
	always_ff @(posedge clk) begin
		forward_x <= emit((FW+1)'(p_s5[0]));
		forward_y <= emit((FW+1)'(p_s5[1]));
		forward_z <= emit((FW+1)'(spn_s5));
		right_x   <= emit(-(FW+1)'(p_s5[2]) + (FW+1)'(p_s5[3]));
		right_y   <= emit(-(FW+1)'(p_s5[4]) - (FW+1)'(p_s5[5]));
		right_z   <= emit(-(FW+1)'(p_s5[6]));
		up_x      <= emit((FW+1)'(p_s5[7]) + (FW+1)'(p_s5[8]));
		up_y      <= emit((FW+1)'(p_s5[9]) - (FW+1)'(p_s5[10]));
		up_z      <= emit((FW+1)'(p_s5[11]));
	end

	// valid shift line alongside the data
	localparam int LAT = NC + 6;
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end
	assign v_s1 = vld_q[0];
	assign done = vld_q[LAT-1] & (v_s1 | ~v_s1);
endmodule
`default_nettype wire

// ----- hdl/e2b_checker.sv -----
// Port checker for euler_to_basis_vectors, bound to the top level.
// Depends on euler_to_basis_vectors_defines.svh.
`default_nettype none
`include "euler_to_basis_vectors_defines.svh"
module e2b_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic signed [15:0] forward_z,
	input wire logic signed [15:0] up_z
);
	`E2B_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
	`E2B_ASSERT_IMPL(a_fz_range, done, forward_z <= 16'sd16384 && forward_z >= -16'sd16384)
	`E2B_ASSERT_IMPL(a_uz_range, done, up_z <= 16'sd16384 && up_z >= -16'sd16384)
	`E2B_ASSERT_IMPL(a_done_after_start, done, $past(start, 11))
endmodule
bind euler_to_basis_vectors e2b_checker u_e2b_checker (.*);
`default_nettype wire

// ----- sim/euler_to_basis_vectors_tb.sv -----
// Self-checking testbench for euler_to_basis_vectors: directed angle table, then random
// orientations, each result compared with an in-bench fixed-point basis-vector predictor or a known pose.
// Depends on e2b_pkg and the euler_to_basis_vectors RTL.
`default_nettype none
module euler_to_basis_vectors_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ABITS = e2b_pkg::ANGLE_BITS_DEF;
	localparam int FBITS = e2b_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM = 1800;
	localparam int N_DIRECTED = 18;
	localparam int LATENCY = 11;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] pitch;
		logic [15:0] yaw;
		logic [15:0] roll;
	} orient_t;

	typedef struct packed {
		logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
	} basis_t;

	typedef struct packed {
		orient_t ang;
		logic    known;
		basis_t  res;
	} dir_row_t;

	logic clk, arst_n, start, busy, done;
	logic [15:0] pitch_angle, yaw_angle, roll_angle;
	logic signed [15:0] forward_x, forward_y, forward_z, right_x, right_y, right_z;
	logic signed [15:0] up_x, up_y, up_z;

	basis_t expected_basis[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	longint cycles = 0;
	dir_row_t angle_table[N_DIRECTED];

	euler_to_basis_vectors DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
		.done(done),
		.forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
		.right_x(right_x), .right_y(right_y), .right_z(right_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Q30 multiply, rounded half up
	function automatic longint unsigned q30_mult(longint unsigned a, longint unsigned b);
		return (a * b + 64'd536870912) >> 30;
	endfunction

	// sin(pi/2 * t), t in Q30
	function automatic longint unsigned quarter_sin(longint unsigned t);
		longint unsigned coef[6];
		longint unsigned t2, acc, p;
		coef = '{64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026994, 64'd172273,
			64'd3864};
		t2 = q30_mult(t, t);
		acc = coef[5];
		for (int k = 4; k >= 0; k--) begin
			p = q30_mult(t2, acc);
			acc = (p > coef[k]) ? 0 : coef[k] - p;
		end
		acc = q30_mult(t, acc);
		return (acc > 64'd1073741824) ? 64'd1073741824 : acc;
	endfunction

	function automatic longint q30_to_fixed(longint unsigned q);
		return longint'((q + (64'd1 << (29 - FBITS))) >> (30 - FBITS));
	endfunction

	// Quadrant-resolved sine and cosine of a binary angle
	function automatic void angle_sincos(logic [15:0] ang, output longint s, output longint c);
		longint unsigned t;
		longint s0, c0;
		t = longint'(ang[ABITS-3:0]) << (32 - ABITS);
		s0 = q30_to_fixed(quarter_sin(t));
		c0 = q30_to_fixed(quarter_sin(64'd1073741824 - t));
		case (ang[ABITS-1:ABITS-2])
			2'd0: begin s = s0;  c = c0;  end
			2'd1: begin s = c0;  c = -s0; end
			2'd2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endfunction

	// Fixed-point product, halves rounded away from zero
	function automatic longint fixed_mult(longint a, longint b);
		longint m;
		m = (((a < 0) ? -a : a) * ((b < 0) ? -b : b) + (longint'(1) << (FBITS - 1))) >> FBITS;
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic logic signed [15:0] clamp_unit(longint v);
		longint one;
		one = longint'(1) << FBITS;
		if (v > one) v = one;
		if (v < -one) v = -one;
		return v[15:0];
	endfunction

	function automatic basis_t predict_basis(orient_t o);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		basis_t b;
		angle_sincos(o.pitch, sp, cp);
		angle_sincos(o.yaw, sy, cy);
		angle_sincos(o.roll, sr, cr);
		srsp = fixed_mult(sr, sp);
		crsp = fixed_mult(cr, sp);
		b.fx = clamp_unit(fixed_mult(cp, cy));
		b.fy = clamp_unit(fixed_mult(cp, sy));
		b.fz = clamp_unit(-sp);
		b.rx = clamp_unit(-fixed_mult(srsp, cy) + fixed_mult(cr, sy));
		b.ry = clamp_unit(-fixed_mult(srsp, sy) - fixed_mult(cr, cy));
		b.rz = clamp_unit(-fixed_mult(sr, cp));
		b.ux = clamp_unit(fixed_mult(crsp, cy) + fixed_mult(sr, sy));
		b.uy = clamp_unit(fixed_mult(crsp, sy) - fixed_mult(sr, cy));
		b.uz = clamp_unit(fixed_mult(cr, cp));
		return b;
	endfunction

	// Compare each result strobe with the oldest expectation
	always @(posedge clk) begin
		basis_t got, want;
		if (arst_n && done) begin
			got = '{forward_x, forward_y, forward_z, right_x, right_y, right_z, up_x, up_y, up_z};
			if (expected_basis.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_basis.pop_front();
				n_checked++;
				if (got !== want) begin
					$display("%0t: basis mismatch expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	// Present one orientation and hold it until transferred
	task automatic send_orientation(orient_t o, logic known, basis_t res);
		start <= 1'b1;
		pitch_angle <= o.pitch;
		yaw_angle <= o.yaw;
		roll_angle <= o.roll;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_basis.push_back(known ? res : predict_basis(o));
		n_sent++;
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 18)) @(posedge clk);
	endtask

	function automatic basis_t pose(int fx, fy, fz, rx, ry, rz, ux, uy, uz);
		basis_t b;
		b = '{16'(fx), 16'(fy), 16'(fz), 16'(rx), 16'(ry), 16'(rz), 16'(ux), 16'(uy), 16'(uz)};
		return b;
	endfunction

	initial begin
		orient_t o;
		int wait_cycles;
		localparam int ONE = 16384;
		arst_n = 1'b0;
		start = 1'b0;
		pitch_angle = '0;
		yaw_angle = '0;
		roll_angle = '0;

		// Level orientation is read directly; the cardinal angles and the rest are predicted
		angle_table[0] = '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1,
			pose(ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE)};
		angle_table[1] = '{'{16'h4000, 16'h0000, 16'h0000}, 1'b0, '0};
		angle_table[2] = '{'{16'h8000, 16'h0000, 16'h0000}, 1'b0, '0};
		angle_table[3] = '{'{16'hC000, 16'h0000, 16'h0000}, 1'b0, '0};
		angle_table[4] = '{'{16'h0000, 16'h4000, 16'h0000}, 1'b0, '0};
		angle_table[5] = '{'{16'h0000, 16'h8000, 16'h0000}, 1'b0, '0};
		angle_table[6] = '{'{16'h0000, 16'hC000, 16'h0000}, 1'b0, '0};
		angle_table[7] = '{'{16'h0000, 16'h0000, 16'h4000}, 1'b0, '0};
		angle_table[8] = '{'{16'h0000, 16'h0000, 16'h8000}, 1'b0, '0};
		angle_table[9] = '{'{16'h0000, 16'h0000, 16'hC000}, 1'b0, '0};
		angle_table[10] = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0};
		angle_table[11] = '{'{16'h0001, 16'h0001, 16'h0001}, 1'b0, '0};
		angle_table[12] = '{'{16'h3FFF, 16'h7FFF, 16'hBFFF}, 1'b0, '0};
		angle_table[13] = '{'{16'h4001, 16'h8001, 16'hC001}, 1'b0, '0};
		angle_table[14] = '{'{16'h2000, 16'h2000, 16'h2000}, 1'b0, '0};
		angle_table[15] = '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0};
		angle_table[16] = '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0};
		angle_table[17] = '{'{16'hE000, 16'h6000, 16'hA000}, 1'b0, '0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, back to back
		foreach (angle_table[i])
			send_orientation(angle_table[i].ang, angle_table[i].known, angle_table[i].res);
		start <= 1'b0;

		// Hold off until the pipeline has drained
		while (expected_basis.size() != 0) @(posedge clk);

		// Random orientations, idle bursts except in the final stretch
		for (int i = 0; i < N_RANDOM; i++) begin
			o.pitch = 16'($urandom);
			o.yaw = 16'($urandom);
			o.roll = 16'($urandom);
			if ($urandom_range(0, 3) == 0) o.pitch[13:0] = 14'($urandom_range(0, 1) ? 0 : 14'h3FFF);
			send_orientation(o, 1'b0, '0);
			if (i < N_RANDOM - 200 && $urandom_range(0, 5) == 0) idle_burst();
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (expected_basis.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4) @(posedge clk);

		$display("Covered %0d orientations (%0d directed), %0d results checked.",
			n_sent, N_DIRECTED, n_checked);
		if (errors == 0 && expected_basis.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d errors, %0d results missing", errors, expected_basis.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
